// File: sv/xsed_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the cross-reference stream entry decoder.
// Has no dependencies; design files that use it refer to it by scoped names.
package xsed_pkg;

    localparam int MAX_SUBSECTIONS_DEF = 8;
    localparam logic [3:0] MAX_FIELD_BYTES = 4'd8;

    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int NUM_W      = 31;
    localparam int OBJ_W      = 32;
    localparam int FIELD_W    = 64;
    localparam int STATUS_W   = 2;
    localparam int WIDTH_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int BYTE_CNT_W = 5;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_DATA   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_ENTRY  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXCESS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_WIDTH  = 2'd2;

    localparam logic [WIDTH_W-1:0] TYPE_WIDTH_RST   = 4'd1;
    localparam logic [WIDTH_W-1:0] SECOND_WIDTH_RST = 4'd4;
    localparam logic [WIDTH_W-1:0] THIRD_WIDTH_RST  = 4'd2;

    localparam logic [FIELD_W-1:0] TYPE_COMPRESSED = 64'd2;
    localparam logic [FIELD_W-1:0] TYPE_DEFAULT    = 64'd1;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data_byte;
        logic [NUM_W-1:0]  sub_start;
        logic [NUM_W-1:0]  sub_count;
    } item_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] type_width;
        logic [WIDTH_W-1:0] second_width;
        logic [WIDTH_W-1:0] third_width;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OBJ_W-1:0]    object_number;
        logic [FIELD_W-1:0]  entry_type;
        logic [FIELD_W-1:0]  second_value;
        logic [FIELD_W-1:0]  third_value;
        logic                mixed_order;
        logic                is_object_zero;
    } result_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic             valid;
        logic             full;
        logic [NUM_W-1:0] start;
        logic [NUM_W-1:0] count;
    } queue_head_t;

    function automatic logic [WIDTH_W-1:0] clip_width(input logic [WIDTH_W-1:0] w);
        return (w > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : w;
    endfunction

endpackage

// File: sv/xsed_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module xsed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/xsed_subsec_queue.sv
`timescale 1ns / 1ps
// Subsection table kept as a queue of non-empty (start, count) pairs, head first.
// Depends on xsed_pkg and xsed_ram.
module xsed_subsec_queue #(
    parameter int MAX_SUBSECTIONS = xsed_pkg::MAX_SUBSECTIONS_DEF,
    localparam int AW = (MAX_SUBSECTIONS > 1) ? $clog2(MAX_SUBSECTIONS) : 1,
    localparam int CW = $clog2(MAX_SUBSECTIONS + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  xsed_pkg::queue_ctrl_t       ctrl,
    input  logic [xsed_pkg::NUM_W-1:0]  push_start,
    input  logic [xsed_pkg::NUM_W-1:0]  push_count,
    output xsed_pkg::queue_head_t       head
);

    localparam int DW = 2 * xsed_pkg::NUM_W;

    logic [CW-1:0] tlen_reg, tlen_next;
    logic [CW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0] cur_idx_reg, cur_idx_next;
    logic          byp_valid_reg, byp_valid_next;
    logic [DW-1:0] byp_data_reg;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata, head_data;

    assign we    = ctrl.append && (push_count != '0);
    assign waddr = wr_ptr_reg[AW-1:0];
    assign wdata = {push_start, push_count};
    assign raddr = cur_idx_next[AW-1:0];

    always_comb begin
        tlen_next    = tlen_reg;
        wr_ptr_next  = wr_ptr_reg;
        cur_idx_next = cur_idx_reg;
        if (ctrl.clear) begin
            tlen_next    = '0;
            wr_ptr_next  = '0;
            cur_idx_next = '0;
        end else begin
            if (ctrl.append) begin
                tlen_next = tlen_reg + CW'(1);
            end
            if (we) begin
                wr_ptr_next = wr_ptr_reg + CW'(1);
            end
            if (ctrl.pop) begin
                cur_idx_next = cur_idx_reg + CW'(1);
            end
        end
        byp_valid_next = we && (waddr == raddr);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tlen_reg      <= '0;
            wr_ptr_reg    <= '0;
            cur_idx_reg   <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            tlen_reg      <= tlen_next;
            wr_ptr_reg    <= wr_ptr_next;
            cur_idx_reg   <= cur_idx_next;
            byp_valid_reg <= byp_valid_next;
        end
        byp_data_reg <= wdata;
    end

    xsed_ram #(
        .WIDTH(DW),
        .DEPTH(MAX_SUBSECTIONS)
    ) u_ram (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    // A pair written in the previous cycle to the head slot is not yet visible at the RAM output.
    assign head_data  = byp_valid_reg ? byp_data_reg : rdata;
    assign head.valid = cur_idx_reg < wr_ptr_reg;
    assign head.full  = tlen_reg >= CW'(MAX_SUBSECTIONS);
    assign head.start = head_data[DW-1:xsed_pkg::NUM_W];
    assign head.count = head_data[xsed_pkg::NUM_W-1:0];

endmodule

// File: sv/xsed_entry_asm.sv
`timescale 1ns / 1ps
// Entry assembly: splits data bytes into three big-endian fields, numbers entries,
// tracks the mixed-order flag and forms the result word. Depends on xsed_pkg.
module xsed_entry_asm (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   fire,
    input  xsed_pkg::item_t        item,
    input  xsed_pkg::cfg_t         cfg,
    input  xsed_pkg::queue_head_t  head,
    output xsed_pkg::queue_ctrl_t  ctrl,
    output logic                   res_valid,
    output xsed_pkg::result_t      res
);

    localparam int BCW = xsed_pkg::BYTE_CNT_W;

    logic [BCW-1:0]                 byte_cnt_reg, byte_cnt_next;
    logic [xsed_pkg::FIELD_W-1:0]   acc_reg [3];
    logic [xsed_pkg::FIELD_W-1:0]   acc_next [3];
    logic [xsed_pkg::FIELD_W-1:0]   acc_shift [3];
    logic [xsed_pkg::NUM_W-1:0]     pos_reg, pos_next;
    logic                           seen_reg, seen_next;
    logic                           mixed_reg, mixed_next;
    logic [BCW-1:0]                 w0, w1, w2, size, bound1, cnt_inc;
    logic [1:0]                     field;
    logic [xsed_pkg::NUM_W-1:0]     pos_inc;
    logic [xsed_pkg::FIELD_W-1:0]   entry_type;
    logic [xsed_pkg::OBJ_W-1:0]     obj;
    logic                           is_comp;
    xsed_pkg::queue_ctrl_t          ctrl_raw;

    assign w0      = BCW'(xsed_pkg::clip_width(cfg.type_width));
    assign w1      = BCW'(xsed_pkg::clip_width(cfg.second_width));
    assign w2      = BCW'(xsed_pkg::clip_width(cfg.third_width));
    assign bound1  = w0 + w1;
    assign size    = bound1 + w2;
    assign cnt_inc = byte_cnt_reg + BCW'(1);
    assign pos_inc = pos_reg + xsed_pkg::NUM_W'(1);

    always_comb begin
        if (byte_cnt_reg < w0) begin
            field = 2'd0;
        end else if (byte_cnt_reg < bound1) begin
            field = 2'd1;
        end else begin
            field = 2'd2;
        end
        for (int f = 0; f < 3; f++) begin
            acc_shift[f] = (field == 2'(f)) ?
                           {acc_reg[f][xsed_pkg::FIELD_W-9:0], item.data_byte} : acc_reg[f];
        end
    end

    assign entry_type = (w0 == '0) ? xsed_pkg::TYPE_DEFAULT : acc_shift[0];
    assign is_comp    = entry_type == xsed_pkg::TYPE_COMPRESSED;
    assign obj        = {1'b0, head.start} + {1'b0, pos_reg};

    always_comb begin
        byte_cnt_next = byte_cnt_reg;
        acc_next      = acc_reg;
        pos_next      = pos_reg;
        seen_next     = seen_reg;
        mixed_next    = mixed_reg;
        ctrl_raw      = '0;
        res_valid     = 1'b0;
        res           = '0;
        res.mixed_order = mixed_reg;
        case (item.op)
            xsed_pkg::OP_CLEAR: begin
                ctrl_raw.clear = 1'b1;
                byte_cnt_next  = '0;
                for (int f = 0; f < 3; f++) begin
                    acc_next[f] = '0;
                end
                pos_next   = '0;
                seen_next  = 1'b0;
                mixed_next = 1'b0;
            end
            xsed_pkg::OP_APPEND: begin
                if (head.full) begin
                    res_valid  = 1'b1;
                    res.status = xsed_pkg::STATUS_FULL;
                end else begin
                    ctrl_raw.append = 1'b1;
                end
            end
            xsed_pkg::OP_DATA: begin
                if ((size == '0) || !head.valid) begin
                    res_valid  = 1'b1;
                    res.status = xsed_pkg::STATUS_EXCESS;
                end else if (cnt_inc < size) begin
                    byte_cnt_next = cnt_inc;
                    acc_next      = acc_shift;
                end else begin
                    byte_cnt_next = '0;
                    for (int f = 0; f < 3; f++) begin
                        acc_next[f] = '0;
                    end
                    if (pos_inc >= head.count) begin
                        ctrl_raw.pop = 1'b1;
                        pos_next     = '0;
                    end else begin
                        pos_next = pos_inc;
                    end
                    if (seen_reg) begin
                        mixed_next = mixed_reg || !is_comp;
                    end else begin
                        seen_next = is_comp;
                    end
                    res_valid          = 1'b1;
                    res.status         = xsed_pkg::STATUS_ENTRY;
                    res.object_number  = obj;
                    res.entry_type     = entry_type;
                    res.second_value   = acc_shift[1];
                    res.third_value    = acc_shift[2];
                    res.mixed_order    = mixed_next;
                    res.is_object_zero = obj == '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign ctrl = fire ? ctrl_raw : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_cnt_reg <= '0;
            for (int f = 0; f < 3; f++) begin
                acc_reg[f] <= '0;
            end
            pos_reg   <= '0;
            seen_reg  <= 1'b0;
            mixed_reg <= 1'b0;
        end else if (fire) begin
            byte_cnt_reg <= byte_cnt_next;
            acc_reg      <= acc_next;
            pos_reg      <= pos_next;
            seen_reg     <= seen_next;
            mixed_reg    <= mixed_next;
        end
    end

endmodule

// File: sv/xref_stream_entry_decoder_core.sv
`timescale 1ns / 1ps
// Cross-reference stream entry decoder: input register, entry assembly, subsection
// queue and output register. Depends on xsed_pkg, xsed_entry_asm, xsed_subsec_queue.
// Throughput: one word per cycle while the output is not held by m_ready; a result passes through
// the input register, then the result register, before it is valid.
// The subsection queue RAM read is registered and bypassed, so it adds no stall.
// Reset (aresetn low, synchronous) empties the table and clears counters and flags;
// widths return to 1, 4 and 2 bytes. The table RAM needs no clearing pass.
module xref_stream_entry_decoder_core #(
    parameter int MAX_SUBSECTIONS = xsed_pkg::MAX_SUBSECTIONS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [xsed_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [xsed_pkg::WIDTH_W-1:0]      cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [xsed_pkg::OP_W-1:0]         s_op,
    input  logic [xsed_pkg::BYTE_W-1:0]       s_data_byte,
    input  logic [xsed_pkg::NUM_W-1:0]        s_sub_start,
    input  logic [xsed_pkg::NUM_W-1:0]        s_sub_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [xsed_pkg::STATUS_W-1:0]     m_status,
    output logic [xsed_pkg::OBJ_W-1:0]        m_object_number,
    output logic [xsed_pkg::FIELD_W-1:0]      m_entry_type,
    output logic [xsed_pkg::FIELD_W-1:0]      m_second_value,
    output logic [xsed_pkg::FIELD_W-1:0]      m_third_value,
    output logic                              m_mixed_order,
    output logic                              m_is_object_zero
);

    xsed_pkg::cfg_t        cfg_reg;
    logic                  in_valid_reg;
    xsed_pkg::item_t       in_item_reg;
    logic                  out_valid_reg;
    xsed_pkg::result_t     out_res_reg;
    logic                  fire;
    logic                  res_valid;
    xsed_pkg::result_t     res;
    xsed_pkg::queue_ctrl_t qctrl;
    xsed_pkg::queue_head_t qhead;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.type_width   <= xsed_pkg::TYPE_WIDTH_RST;
            cfg_reg.second_width <= xsed_pkg::SECOND_WIDTH_RST;
            cfg_reg.third_width  <= xsed_pkg::THIRD_WIDTH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                xsed_pkg::CFG_TYPE_WIDTH:   cfg_reg.type_width   <= cfg_data;
                xsed_pkg::CFG_SECOND_WIDTH: cfg_reg.second_width <= cfg_data;
                xsed_pkg::CFG_THIRD_WIDTH:  cfg_reg.third_width  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_valid && s_ready) begin
            in_item_reg.op        <= s_op;
            in_item_reg.data_byte <= s_data_byte;
            in_item_reg.sub_start <= s_sub_start;
            in_item_reg.sub_count <= s_sub_count;
        end
        if (fire && res_valid) begin
            out_res_reg <= res;
        end
    end

    xsed_entry_asm u_entry (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .item     (in_item_reg),
        .cfg      (cfg_reg),
        .head     (qhead),
        .ctrl     (qctrl),
        .res_valid(res_valid),
        .res      (res)
    );

    xsed_subsec_queue #(
        .MAX_SUBSECTIONS(MAX_SUBSECTIONS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (qctrl),
        .push_start(in_item_reg.sub_start),
        .push_count(in_item_reg.sub_count),
        .head      (qhead)
    );

    assign m_valid          = out_valid_reg;
    assign m_status         = out_res_reg.status;
    assign m_object_number  = out_res_reg.object_number;
    assign m_entry_type     = out_res_reg.entry_type;
    assign m_second_value   = out_res_reg.second_value;
    assign m_third_value    = out_res_reg.third_value;
    assign m_mixed_order    = out_res_reg.mixed_order;
    assign m_is_object_zero = out_res_reg.is_object_zero;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for xref_stream_entry_decoder_core: a directed table, then random
// phases of subsection loads and entry bytes under several width settings, each checked
// against a behavioral decoder kept in step with every accepted word. Depends on xsed_pkg and the core.
module testbench;
    import xsed_pkg::*;

    localparam int TABLE_DEPTH = MAX_SUBSECTIONS_DEF;
    localparam int DIR_ROWS = 26;
    localparam int NUM_PHASES = 12;
    localparam int WORDS_PER_PHASE = 32;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT = 100000;
    localparam int REPORT_LIMIT = 10;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        item_t   w;
        logic    typed;
        result_t want;
    } stim_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [WIDTH_W-1:0]    cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [OP_W-1:0]       s_op;
    logic [BYTE_W-1:0]     s_data_byte;
    logic [NUM_W-1:0]      s_sub_start;
    logic [NUM_W-1:0]      s_sub_count;
    logic                  m_valid;
    logic                  m_ready;
    logic [STATUS_W-1:0]   m_status;
    logic [OBJ_W-1:0]      m_object_number;
    logic [FIELD_W-1:0]    m_entry_type;
    logic [FIELD_W-1:0]    m_second_value;
    logic [FIELD_W-1:0]    m_third_value;
    logic                  m_mixed_order;
    logic                  m_is_object_zero;

    xref_stream_entry_decoder_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_data_byte      (s_data_byte),
        .s_sub_start      (s_sub_start),
        .s_sub_count      (s_sub_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_object_number  (m_object_number),
        .m_entry_type     (m_entry_type),
        .m_second_value   (m_second_value),
        .m_third_value    (m_third_value),
        .m_mixed_order    (m_mixed_order),
        .m_is_object_zero (m_is_object_zero)
    );

    cfg_t cfg_now = '{type_width: TYPE_WIDTH_RST, second_width: SECOND_WIDTH_RST,
                      third_width: THIRD_WIDTH_RST};
    logic [NUM_W-1:0]   sub_first [TABLE_DEPTH];
    logic [NUM_W-1:0]   sub_len [TABLE_DEPTH];
    int unsigned        sub_used = 0;
    int unsigned        sub_at = 0;
    int unsigned        byte_at = 0;
    logic [NUM_W-1:0]   entry_at = '0;
    logic [FIELD_W-1:0] field_acc [3] = '{'0, '0, '0};
    bit                 compressed_seen = 1'b0;
    bit                 order_broken = 1'b0;

    stim_t   dir_table [DIR_ROWS];
    stim_t   word_backlog [$];
    stim_t   live_word;
    result_t awaited_records [$];
    int unsigned words_queued = 0;
    int unsigned words_taken = 0;
    int unsigned mismatches = 0;
    int unsigned entries_seen = 0;
    int unsigned excess_seen = 0;
    int unsigned full_seen = 0;
    bit steady = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int field_bytes(logic [WIDTH_W-1:0] w);
        return (w >= MAX_FIELD_BYTES) ? int'(MAX_FIELD_BYTES) : int'(w);
    endfunction

    function automatic int unsigned pause_cycles();
        if (steady) begin
            return 0;
        end
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 18);
            1: return $urandom_range(0, 3);
            default: return 0;
        endcase
    endfunction

    function automatic stim_t row(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b,
                                  logic [NUM_W-1:0] st, logic [NUM_W-1:0] ct);
        stim_t r;
        r = '0;
        r.w.op = op;
        r.w.data_byte = b;
        r.w.sub_start = st;
        r.w.sub_count = ct;
        return r;
    endfunction

    function automatic stim_t checked_row(logic [OP_W-1:0] op, logic [BYTE_W-1:0] b,
                                          logic [NUM_W-1:0] st, logic [NUM_W-1:0] ct,
                                          result_t want);
        stim_t r;
        r = row(op, b, st, ct);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic result_t status_res(logic [STATUS_W-1:0] st, logic mixed);
        result_t r;
        r = '0;
        r.status = st;
        r.mixed_order = mixed;
        return r;
    endfunction

    function automatic result_t entry_res(logic [OBJ_W-1:0] obj, logic [FIELD_W-1:0] ty,
                                          logic [FIELD_W-1:0] sec, logic [FIELD_W-1:0] thi,
                                          logic mixed, logic zero);
        result_t r;
        r.status = STATUS_ENTRY;
        r.object_number = obj;
        r.entry_type = ty;
        r.second_value = sec;
        r.third_value = thi;
        r.mixed_order = mixed;
        r.is_object_zero = zero;
        return r;
    endfunction

    // Advances the decoder state by one word and gives the record it produces, if any.
    task automatic decode_word(input item_t w, output bit produced, output result_t r);
        int w0, w1, w2, size, f;
        logic [FIELD_W-1:0] ty;
        logic [OBJ_W-1:0] obj;
        produced = 1'b0;
        r = '0;
        case (w.op)
            OP_CLEAR: begin
                sub_used = 0;
                sub_at = 0;
                entry_at = '0;
                byte_at = 0;
                field_acc = '{'0, '0, '0};
                compressed_seen = 1'b0;
                order_broken = 1'b0;
            end
            OP_APPEND: begin
                if (sub_used >= TABLE_DEPTH) begin
                    produced = 1'b1;
                    r = status_res(STATUS_FULL, order_broken);
                end else begin
                    sub_first[sub_used] = w.sub_start;
                    sub_len[sub_used] = w.sub_count;
                    sub_used++;
                end
            end
            OP_DATA: begin
                w0 = field_bytes(cfg_now.type_width);
                w1 = field_bytes(cfg_now.second_width);
                w2 = field_bytes(cfg_now.third_width);
                size = w0 + w1 + w2;
                while (sub_at < sub_used && entry_at >= sub_len[sub_at]) begin
                    sub_at++;
                    entry_at = '0;
                end
                if (size == 0 || sub_at >= sub_used) begin
                    produced = 1'b1;
                    r = status_res(STATUS_EXCESS, order_broken);
                end else begin
                    f = (byte_at < w0) ? 0 : (byte_at < w0 + w1) ? 1 : 2;
                    field_acc[f] = {field_acc[f][FIELD_W-BYTE_W-1:0], w.data_byte};
                    byte_at++;
                    if (byte_at >= size) begin
                        ty = (w0 == 0) ? TYPE_DEFAULT : field_acc[0];
                        obj = {1'b0, sub_first[sub_at]} + {1'b0, entry_at};
                        entry_at++;
                        if (entry_at >= sub_len[sub_at]) begin
                            sub_at++;
                            entry_at = '0;
                        end
                        if (compressed_seen) begin
                            if (ty != TYPE_COMPRESSED) order_broken = 1'b1;
                        end else if (ty == TYPE_COMPRESSED) begin
                            compressed_seen = 1'b1;
                        end
                        produced = 1'b1;
                        r = entry_res(obj, ty, field_acc[1], field_acc[2], order_broken,
                                      obj == '0);
                        field_acc = '{'0, '0, '0};
                        byte_at = 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(string name, logic [FIELD_W-1:0] want,
                                 logic [FIELD_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: %s differs: expected %0h, got %0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin : watch
        bit produced;
        result_t predicted;
        result_t seen;
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decode_word(live_word.w, produced, predicted);
                if (live_word.typed) begin
                    awaited_records = {awaited_records, live_word.want};
                end else if (produced) begin
                    awaited_records = {awaited_records, predicted};
                end
                words_taken++;
            end
            if (m_valid && m_ready) begin
                seen.status = m_status;
                seen.object_number = m_object_number;
                seen.entry_type = m_entry_type;
                seen.second_value = m_second_value;
                seen.third_value = m_third_value;
                seen.mixed_order = m_mixed_order;
                seen.is_object_zero = m_is_object_zero;
                case (seen.status)
                    STATUS_ENTRY: entries_seen++;
                    STATUS_EXCESS: excess_seen++;
                    STATUS_FULL: full_seen++;
                    default: ;
                endcase
                if (awaited_records.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: record with none awaited, status %0d", $time,
                                 seen.status);
                    end
                end else begin
                    want = awaited_records.pop_front();
                    compare_field("status", want.status, seen.status);
                    compare_field("object_number", want.object_number, seen.object_number);
                    compare_field("entry_type", want.entry_type, seen.entry_type);
                    compare_field("second_value", want.second_value, seen.second_value);
                    compare_field("third_value", want.third_value, seen.third_value);
                    compare_field("mixed_order", want.mixed_order, seen.mixed_order);
                    compare_field("is_object_zero", want.is_object_zero,
                                  seen.is_object_zero);
                end
            end
        end
    end

    initial begin : word_driver
        int unsigned gap;
        s_valid = 1'b0;
        s_op = OP_CLEAR;
        s_data_byte = '0;
        s_sub_start = '0;
        s_sub_count = '0;
        live_word = '0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (word_backlog.size() == 0) begin
                s_valid <= 1'b0;
            end else begin
                gap = pause_cycles();
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
                live_word = word_backlog.pop_front();
                s_valid <= 1'b1;
                s_op <= live_word.w.op;
                s_data_byte <= live_word.w.data_byte;
                s_sub_start <= live_word.w.sub_start;
                s_sub_count <= live_word.w.sub_count;
                @(posedge aclk);
                while (!s_ready) @(posedge aclk);
            end
        end
    end

    initial begin : record_sink
        int unsigned hold;
        hold = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
                if (aresetn && m_valid) hold = pause_cycles();
            end
        end
    end

    task automatic queue_word(stim_t s);
        word_backlog = {word_backlog, s};
        words_queued++;
    endtask

    task automatic wait_quiet();
        int guard;
        guard = 0;
        while ((words_taken != words_queued || awaited_records.size() != 0) &&
               guard < QUIET_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_widths(cfg_t c);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [WIDTH_W-1:0] val [3];
        int i;
        idx = '{CFG_TYPE_WIDTH, CFG_SECOND_WIDTH, CFG_THIRD_WIDTH};
        val = '{c.type_width, c.second_width, c.third_width};
        for (i = 0; i < 3; i++) begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_now = c;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [NUM_W-1:0] pick_start();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return NUM_W'($urandom);
        endcase
    endfunction

    function automatic logic [NUM_W-1:0] pick_count();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return NUM_W'($urandom);
            default: return NUM_W'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [WIDTH_W-1:0] pick_width();
        if ($urandom_range(0, 4) == 0) begin
            return WIDTH_W'($urandom_range(9, 15));
        end
        return WIDTH_W'($urandom_range(0, 4));
    endfunction

    task automatic queue_append();
        queue_word(row(OP_APPEND, BYTE_W'($urandom), pick_start(), pick_count()));
    endtask

    // Mostly well-formed streams: a clear, a few subsections, then whole entries whose
    // type bytes favor free, uncompressed and compressed codes. Some entries are cut
    // short, some appends overrun the table, and a few words are pure noise.
    task automatic plan_stream(int unsigned budget);
        int unsigned first, n, k, w0, size;
        logic [BYTE_W-1:0] b;
        first = words_queued;
        w0 = field_bytes(cfg_now.type_width);
        size = w0 + field_bytes(cfg_now.second_width) + field_bytes(cfg_now.third_width);
        if ($urandom_range(0, 3) != 0) begin
            queue_word(row(OP_CLEAR, BYTE_W'($urandom), NUM_W'($urandom), NUM_W'($urandom)));
            n = $urandom_range(1, 3);
            repeat (n) queue_append();
        end
        while (words_queued - first < budget) begin
            case ($urandom_range(0, 11))
                0: queue_word(row(OP_W'($urandom_range(0, 3)), BYTE_W'($urandom),
                                  NUM_W'($urandom), NUM_W'($urandom)));
                1: queue_append();
                2: begin
                    n = ($urandom_range(0, 2) == 0) ? $urandom_range(4, 10) : 1;
                    repeat (n) queue_append();
                end
                default: begin
                    if (size == 0) begin
                        n = $urandom_range(1, 2);
                    end else if ($urandom_range(0, 7) == 0) begin
                        n = $urandom_range(0, size - 1);
                    end else begin
                        n = size;
                    end
                    for (k = 0; k < n; k++) begin
                        if (k + 1 == w0) begin
                            b = ($urandom_range(0, 5) == 0) ? BYTE_W'($urandom)
                                                            : BYTE_W'($urandom_range(0, 2));
                        end else if (k < w0) begin
                            b = ($urandom_range(0, 5) == 0) ? BYTE_W'($urandom) : '0;
                        end else begin
                            b = BYTE_W'($urandom);
                        end
                        queue_word(row(OP_DATA, b, NUM_W'($urandom), NUM_W'($urandom)));
                    end
                end
            endcase
        end
    endtask

    initial begin : run
        cfg_t plan;
        int p, i;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TYPE_WIDTH;
        cfg_data = '0;
        dir_table = '{
            checked_row(OP_DATA, 8'h5A, '0, '0, status_res(STATUS_EXCESS, 1'b0)),
            row(OP_UNUSED, 8'hFF, '1, '1),
            row(OP_APPEND, 8'h00, '0, 31'd1),
            row(OP_APPEND, 8'h00, '1, '0),
            row(OP_APPEND, 8'h00, '1, '1),
            row(OP_DATA, 8'h02, '0, '0),
            row(OP_DATA, 8'hFF, '0, '0),
            row(OP_DATA, 8'hFF, '0, '0),
            row(OP_DATA, 8'hFF, '0, '0),
            row(OP_DATA, 8'hFF, '0, '0),
            row(OP_DATA, 8'h00, '0, '0),
            checked_row(OP_DATA, 8'h01, '0, '0,
                        entry_res('0, 64'd2, 64'hFFFF_FFFF, 64'd1, 1'b0, 1'b1)),
            row(OP_APPEND, 8'h00, 31'd10, 31'd1),
            row(OP_APPEND, 8'h00, 31'd20, 31'd1),
            row(OP_APPEND, 8'h00, 31'd30, 31'd1),
            row(OP_APPEND, 8'h00, 31'd40, 31'd1),
            row(OP_APPEND, 8'h00, 31'd50, 31'd1),
            checked_row(OP_APPEND, 8'h00, 31'd60, 31'd1, status_res(STATUS_FULL, 1'b0)),
            row(OP_DATA, 8'h01, '0, '0),
            row(OP_DATA, 8'h00, '0, '0),
            row(OP_DATA, 8'h00, '0, '0),
            row(OP_DATA, 8'h00, '0, '0),
            row(OP_DATA, 8'h00, '0, '0),
            row(OP_DATA, 8'hFF, '0, '0),
            checked_row(OP_DATA, 8'hFF, '0, '0,
                        entry_res(32'h7FFF_FFFF, 64'd1, 64'd0, 64'hFFFF, 1'b1, 1'b0)),
            row(OP_CLEAR, 8'h00, '0, '0)
        };
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        for (i = 0; i < DIR_ROWS; i++) queue_word(dir_table[i]);
        wait_quiet();
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: plan = '{type_width: 4'd0, second_width: 4'd0, third_width: 4'd0};
                1: plan = '{type_width: 4'd8, second_width: 4'd8, third_width: 4'd8};
                2: plan = '{type_width: 4'd15, second_width: 4'd9, third_width: 4'd12};
                3: plan = '{type_width: 4'd0, second_width: 4'd2, third_width: 4'd1};
                4: plan = '{type_width: 4'd2, second_width: 4'd0, third_width: 4'd0};
                default: begin
                    plan.type_width = pick_width();
                    plan.second_width = pick_width();
                    plan.third_width = pick_width();
                end
            endcase
            write_widths(plan);
            steady = (p % 3 == 2);
            plan_stream(WORDS_PER_PHASE);
            wait_quiet();
        end
        if (words_taken != words_queued) begin
            $display("%0d words never accepted", words_queued - words_taken);
            mismatches += words_queued - words_taken;
        end
        if (awaited_records.size() != 0) begin
            $display("%0d records never arrived", awaited_records.size());
            mismatches += awaited_records.size();
        end
        $display("Ran %0d words through %0d width settings.", words_taken, NUM_PHASES + 1);
        $display("Checked %0d entries, %0d excess bytes and %0d table-full reports.",
                 entries_seen, excess_seen, full_seen);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Timed out with %0d records outstanding", awaited_records.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
